FILE: rtl/core/rrts_pkg.sv
// Shared types and constants for the round-robin task tick scheduler.
`timescale 1ns / 1ps

package rrts_pkg;

  localparam int NUM_SLOTS_DEF = 16;

  localparam logic [1:0] OP_TICK = 2'd0;
  localparam logic [1:0] OP_ADD  = 2'd1;
  localparam logic [1:0] OP_DEL  = 2'd2;
  localparam logic [1:0] OP_RSVD = 2'd3;

  localparam logic [15:0] RELOAD_RST = 16'hFFFF;

  typedef enum logic [1:0] {
    CMD_NOP,
    CMD_TICK,
    CMD_ADD,
    CMD_DEL
  } cmd_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [3:0]  slot_id;
    logic [15:0] task_handle;
  } in_item_t;

  typedef struct packed {
    logic        task_ran;
    logic [3:0]  run_slot;
    logic [15:0] run_handle;
    logic        chain_old;
    logic        add_ok;
    logic [3:0]  added_slot;
  } out_item_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [3:0]  slot_id;
    logic [15:0] task_handle;
  } q_entry_t;

  typedef struct packed {
    logic     valid;
    q_entry_t entry;
  } q_head_t;

endpackage

FILE: rtl/core/round_robin_task_tick_scheduler_core.sv
// Top level of the round-robin task tick scheduler.
// A command is queued, executed from the queue head in ST_EXEC and strobed out in ST_RESP.
// The back end takes no new command until the response state of the last one is over.
// A two-entry command queue raises busy when full; the receiver cannot stall.
// Reset: synchronous active low; all slots inactive, pointer and clicks zero, reload 65535.
`timescale 1ns / 1ps

module round_robin_task_tick_scheduler_core import rrts_pkg::*; #(
  parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  in_item_t    in_data,
  output logic        out_valid,
  output out_item_t   out_data,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);

  q_head_t head;
  logic    pop;

  rrts_front #(
    .NUM_SLOTS(NUM_SLOTS)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .in_data(in_data),
    .pop    (pop),
    .head   (head)
  );

  rrts_back #(
    .NUM_SLOTS(NUM_SLOTS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head     (head),
    .pop      (pop),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .out_valid(out_valid),
    .out_data (out_data)
  );

endmodule

FILE: rtl/core/rrts_front.sv
// Front end: accepts and classifies commands into a two-entry queue.
`timescale 1ns / 1ps

module rrts_front import rrts_pkg::*; #(
  parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  in_item_t in_data,
  input  logic     pop,
  output q_head_t  head
);

  localparam int DEPTH = 2;

  q_entry_t   q_mem [DEPTH];
  logic       rd_ptr_r;
  logic       wr_ptr_r;
  logic [1:0] count_r;
  logic       push;
  q_entry_t   cls;

  always_comb begin
    cls.slot_id     = in_data.slot_id;
    cls.task_handle = in_data.task_handle;
    case (in_data.operation)
      OP_TICK: cls.cmd = CMD_TICK;
      OP_ADD:  cls.cmd = CMD_ADD;
      OP_DEL:  cls.cmd = (32'(in_data.slot_id) < NUM_SLOTS) ? CMD_DEL : CMD_NOP;
      default: cls.cmd = CMD_NOP;
    endcase
  end

  assign busy       = (count_r == 2'(DEPTH));
  assign push       = start && !busy;
  assign head.valid = (count_r != 2'd0);
  assign head.entry = q_mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= 1'b0;
      wr_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head.valid)
    else $error("pop from empty queue");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= 2'(DEPTH))
    else $error("queue count overflow");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |=> count_r == $past(count_r) + 2'd1)
    else $error("queue count did not advance on push");
`endif

endmodule

FILE: rtl/core/rrts_back.sv
// Back end: slot table, round-robin selection, click accumulator and results.
`timescale 1ns / 1ps

module rrts_back import rrts_pkg::*; #(
  parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  q_head_t     head,
  output logic        pop,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  output logic        out_valid,
  output out_item_t   out_data
);

  localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  typedef enum logic {
    ST_EXEC,
    ST_RESP
  } state_t;

  state_t              state_r;
  logic [NUM_SLOTS-1:0] active_r;
  logic [SLOT_W-1:0]   next_slot_r;
  logic [15:0]         click_r;
  logic [15:0]         reload_r;
  logic                ran_r;
  logic [SLOT_W-1:0]   run_slot_r;
  logic                chain_r;
  logic                aok_r;
  logic [SLOT_W-1:0]   aslot_r;
  logic [15:0]         handle_mem [NUM_SLOTS];
  logic [15:0]         rd_data_r;

  logic                hi_found;
  logic [SLOT_W-1:0]   hi_idx;
  logic                any_active;
  logic [SLOT_W-1:0]   lo_idx;
  logic [SLOT_W-1:0]   sel_idx;
  logic                free_found;
  logic [SLOT_W-1:0]   free_idx;
  logic [SLOT_W-1:0]   del_idx;
  logic [16:0]         click_sum;
  logic                add_wr;

  always_comb begin
    hi_found   = 1'b0;
    hi_idx     = '0;
    any_active = 1'b0;
    lo_idx     = '0;
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (active_r[i]) begin
        any_active = 1'b1;
        lo_idx     = SLOT_W'(i);
        if (SLOT_W'(i) >= next_slot_r) begin
          hi_found = 1'b1;
          hi_idx   = SLOT_W'(i);
        end
      end else begin
        free_found = 1'b1;
        free_idx   = SLOT_W'(i);
      end
    end
  end

  assign sel_idx   = hi_found ? hi_idx : lo_idx;
  assign del_idx   = SLOT_W'(head.entry.slot_id);
  assign click_sum = {1'b0, click_r} + {1'b0, reload_r};
  assign pop       = head.valid && (state_r == ST_EXEC);
  assign add_wr    = pop && (head.entry.cmd == CMD_ADD) && free_found;

  always_ff @(posedge clk) begin
    if (add_wr) begin
      handle_mem[free_idx] <= head.entry.task_handle;
    end
    rd_data_r <= handle_mem[sel_idx];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_EXEC;
      active_r    <= '0;
      next_slot_r <= '0;
      click_r     <= '0;
      reload_r    <= RELOAD_RST;
      ran_r       <= 1'b0;
      run_slot_r  <= '0;
      chain_r     <= 1'b0;
      aok_r       <= 1'b0;
      aslot_r     <= '0;
    end else begin
      case (state_r)
        ST_EXEC: begin
          if (pop) begin
            state_r    <= ST_RESP;
            ran_r      <= 1'b0;
            run_slot_r <= '0;
            chain_r    <= 1'b0;
            aok_r      <= 1'b0;
            aslot_r    <= '0;
            case (head.entry.cmd)
              CMD_TICK: begin
                if (any_active) begin
                  ran_r       <= 1'b1;
                  run_slot_r  <= sel_idx;
                  next_slot_r <= (32'(sel_idx) == NUM_SLOTS - 1) ? '0
                                 : sel_idx + SLOT_W'(1);
                end
                if (click_sum[16]) begin
                  click_r <= '0;
                  chain_r <= 1'b1;
                end else begin
                  click_r <= click_sum[15:0];
                end
              end
              CMD_ADD: begin
                if (free_found) begin
                  active_r[free_idx] <= 1'b1;
                  aok_r              <= 1'b1;
                  aslot_r            <= free_idx;
                end
              end
              CMD_DEL: begin
                active_r[del_idx] <= 1'b0;
              end
              default: begin
              end
            endcase
          end
        end
        ST_RESP: begin
          state_r <= ST_EXEC;
        end
        default: begin
          state_r <= ST_EXEC;
        end
      endcase
      if (cfg_we) begin
        reload_r <= cfg_wdata;
        click_r  <= '0;
      end
    end
  end

  assign out_valid           = (state_r == ST_RESP);
  assign out_data.task_ran   = ran_r;
  assign out_data.run_slot   = 4'(run_slot_r);
  assign out_data.run_handle = ran_r ? rd_data_r : 16'd0;
  assign out_data.chain_old  = chain_r;
  assign out_data.add_ok     = aok_r;
  assign out_data.added_slot = 4'(aslot_r);

`ifndef NO_ASSERTIONS
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(next_slot_r) < NUM_SLOTS)
    else $error("next slot pointer out of range");

  a_ran_active: assert property (@(posedge clk) disable iff (!rst_n)
    pop && head.entry.cmd == CMD_TICK && any_active |=> active_r[run_slot_r])
    else $error("selected slot is not active");

  a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.add_ok && (out_data.task_ran || out_data.chain_old)))
    else $error("add and tick results mixed");
`endif

endmodule

FILE: tb/round_robin_task_tick_scheduler_core_tb.sv
// Testbench for the round-robin task tick scheduler: directed and random commands against a slot-table model.
`timescale 1ns / 1ps

module round_robin_task_tick_scheduler_core_tb import rrts_pkg::*; ();

  localparam int STALL_LIMIT = 1000;

  class sched_tracker;
    bit          slot_live[NUM_SLOTS_DEF];
    logic [15:0] slot_hdl[NUM_SLOTS_DEF];
    logic [3:0]  rr_ptr;
    logic [16:0] clicks;
    logic [15:0] reload;
    out_item_t   expected_results[$];
    int          mismatches;

    function new();
      foreach (slot_live[k]) begin
        slot_live[k] = 1'b0;
        slot_hdl[k]  = '0;
      end
      rr_ptr     = '0;
      clicks     = '0;
      reload     = RELOAD_RST;
      mismatches = 0;
    endfunction

    function void load_reload(logic [15:0] value);
      reload = value;
      clicks = '0;
    endfunction

    function out_item_t predict_outcome(in_item_t cmd);
      out_item_t r;
      int        s;
      bit        found;
      r     = '0;
      found = 1'b0;
      case (cmd.operation)
        OP_TICK: begin
          for (int k = 0; k < NUM_SLOTS_DEF; k++) begin
            s = (rr_ptr + k) % NUM_SLOTS_DEF;
            if (!found && slot_live[s]) begin
              found        = 1'b1;
              r.task_ran   = 1'b1;
              r.run_slot   = s[3:0];
              r.run_handle = slot_hdl[s];
            end
          end
          if (found) rr_ptr = (r.run_slot + 1) % NUM_SLOTS_DEF;
          clicks = clicks + {1'b0, reload};
          if (clicks >= 17'h10000) begin
            clicks      = '0;
            r.chain_old = 1'b1;
          end
        end
        OP_ADD: begin
          for (int k = 0; k < NUM_SLOTS_DEF; k++) begin
            if (!found && !slot_live[k]) begin
              found        = 1'b1;
              slot_live[k] = 1'b1;
              slot_hdl[k]  = cmd.task_handle;
              r.add_ok     = 1'b1;
              r.added_slot = k[3:0];
            end
          end
        end
        OP_DEL: begin
          if (cmd.slot_id < NUM_SLOTS_DEF && slot_live[cmd.slot_id]) begin
            slot_live[cmd.slot_id] = 1'b0;
            slot_hdl[cmd.slot_id]  = '0;
          end
        end
        default: ;
      endcase
      return r;
    endfunction

    function void note_command(in_item_t cmd);
      expected_results.push_back(predict_outcome(cmd));
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      bit        bad;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%t: result with nothing expected: %h", $realtime, got);
        return;
      end
      want = expected_results.pop_front();
      bad  = (got.task_ran !== want.task_ran) || (got.run_slot !== want.run_slot) ||
             (got.run_handle !== want.run_handle) || (got.chain_old !== want.chain_old) ||
             (got.add_ok !== want.add_ok) || (got.added_slot !== want.added_slot);
      if (bad) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"%t: mismatch ran/slot/handle/chain/ok/added",
                    " exp %b/%0d/%h/%b/%b/%0d got %b/%0d/%h/%b/%b/%0d"},
                   $realtime, want.task_ran, want.run_slot, want.run_handle, want.chain_old,
                   want.add_ok, want.added_slot, got.task_ran, got.run_slot, got.run_handle,
                   got.chain_old, got.add_ok, got.added_slot);
      end
    endfunction

    function int pending();
      return expected_results.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  in_item_t    in_data = '0;
  logic        out_valid;
  out_item_t   out_data;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;

  sched_tracker tracker = new();
  int           quiet_cycles = 0;
  bit           burst_mode = 1'b0;

  round_robin_task_tick_scheduler_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) tracker.note_command(in_data);
      if (out_valid) tracker.check_result(out_data);
    end
    if ((start && !busy) || out_valid || cfg_we) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= STALL_LIMIT) begin
        $display("%t: watchdog expired, no transaction for %0d cycles", $realtime, STALL_LIMIT);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  function automatic in_item_t mk_cmd(logic [1:0] op, logic [3:0] id, logic [15:0] hdl);
    in_item_t c;
    c.operation   = op;
    c.slot_id     = id;
    c.task_handle = hdl;
    return c;
  endfunction

  task automatic send_cmd(in_item_t cmd);
    int gap;
    if ($urandom_range(0, 19) == 0) burst_mode = !burst_mode;
    gap = burst_mode ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= cmd;
    do @(posedge clk); while (busy);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reload(logic [15:0] value);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    tracker.load_reload(value);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_random(int count, int add_pct);
    int        r;
    logic [1:0] op;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 5) op = OP_RSVD;
      else if (r < 5 + add_pct) op = OP_ADD;
      else if (r < 30 + add_pct) op = OP_DEL;
      else op = OP_TICK;
      send_cmd(mk_cmd(op, 4'($urandom_range(0, 15)), 16'($urandom_range(0, 65535))));
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_cmd(mk_cmd(OP_TICK, 4'd0, 16'h0000));
    send_cmd(mk_cmd(OP_RSVD, 4'd15, 16'hFFFF));
    send_cmd(mk_cmd(OP_DEL, 4'd7, 16'h0000));
    send_cmd(mk_cmd(OP_ADD, 4'd0, 16'h0000));
    send_cmd(mk_cmd(OP_ADD, 4'd15, 16'hFFFF));
    send_cmd(mk_cmd(OP_TICK, 4'd0, 16'h0000));
    send_cmd(mk_cmd(OP_TICK, 4'd0, 16'h0000));
    send_cmd(mk_cmd(OP_TICK, 4'd0, 16'h0000));
    for (int i = 0; i < 14; i++)
      send_cmd(mk_cmd(OP_ADD, 4'($urandom_range(0, 15)), 16'($urandom_range(0, 65535))));
    send_cmd(mk_cmd(OP_ADD, 4'd0, 16'hA5A5));
    send_cmd(mk_cmd(OP_DEL, 4'd15, 16'hFFFF));
    send_cmd(mk_cmd(OP_TICK, 4'd0, 16'h0000));

    write_reload(16'd1);
    run_random(100, 35);
    write_reload(16'h8000);
    run_random(100, 20);
    write_reload(16'hFFFF);
    run_random(100, 30);
    write_reload(16'($urandom_range(2, 65534)));
    run_random(100, 25);

    drain();
    if (tracker.mismatches == 0 && tracker.pending() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
